// ===== rtl/pit_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types, constants and helpers of the prescaled interval timer.
// ----------------------------------------------------------------------------
package pit_pkg;

    // field widths
    localparam int unsigned TIMER_W = 8;
    localparam int unsigned FLAG_W  = 2;
    localparam int unsigned COUNT_W = 11;
    localparam int unsigned SEL_W   = 2;

    // stream data widths, padded to whole bytes
    localparam int unsigned IN_DATA_W  = 16;
    localparam int unsigned OUT_DATA_W = 16;

    // prescale choices
    localparam logic [SEL_W-1:0] SEL_DIV1    = 2'd0;
    localparam logic [SEL_W-1:0] SEL_DIV8    = 2'd1;
    localparam logic [SEL_W-1:0] SEL_DIV64   = 2'd2;
    localparam logic [SEL_W-1:0] SEL_DIV1024 = 2'd3;

    localparam logic [COUNT_W-1:0] DIV_1    = 11'd1;
    localparam logic [COUNT_W-1:0] DIV_8    = 11'd8;
    localparam logic [COUNT_W-1:0] DIV_64   = 11'd64;
    localparam logic [COUNT_W-1:0] DIV_1024 = 11'd1024;

    localparam logic [TIMER_W-1:0] TIMER_RELOAD = 8'hFF;
    localparam logic [FLAG_W-1:0]  FLAGS_SET    = 2'b11;
    localparam logic [FLAG_W-1:0]  FLAGS_CLEAR  = 2'b00;

    // timer state carried from cycle to cycle
    typedef struct packed {
        logic [TIMER_W-1:0] timer;
        logic [FLAG_W-1:0]  flags;
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] interval;
    } t_state;

    localparam t_state STATE_RESET = '{
        timer:    '0,
        flags:    FLAGS_CLEAR,
        count:    DIV_1024,
        interval: DIV_1024
    };

    // divider interval for a prescale choice
    function automatic logic [COUNT_W-1:0] f_prescale(input logic [SEL_W-1:0] sel);
        logic [COUNT_W-1:0] v;
        unique case (sel)
            SEL_DIV1:    v = DIV_1;
            SEL_DIV8:    v = DIV_8;
            SEL_DIV64:   v = DIV_64;
            SEL_DIV1024: v = DIV_1024;
            default:     v = DIV_1024;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/pit_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_step
// Next-state logic of one machine cycle: optional write with its immediate
// pulse, then the divider decrement and its pulse.
// ----------------------------------------------------------------------------
module pit_step (
    input  pit_pkg::t_state                     i_cur,
    input  logic                                i_write_valid,
    input  logic [pit_pkg::TIMER_W-1:0]         i_write_value,
    input  logic [pit_pkg::SEL_W-1:0]           i_prescale_select,
    output pit_pkg::t_state                     o_nxt,
    output logic                                o_underflow
);

    pit_pkg::t_state    s_wr;
    pit_pkg::t_state    s_dec;
    logic               wr_under;
    logic               cnt_under;
    logic [pit_pkg::COUNT_W-1:0] iv;

    // write: load timer and divider, then pulse at once
    always_comb begin
        iv       = pit_pkg::f_prescale(i_prescale_select);
        s_wr     = i_cur;
        wr_under = 1'b0;
        if (i_write_valid) begin
            if (i_write_value == '0) begin
                s_wr.timer    = pit_pkg::TIMER_RELOAD;
                s_wr.flags    = pit_pkg::FLAGS_SET;
                s_wr.count    = pit_pkg::DIV_1;
                s_wr.interval = pit_pkg::DIV_1;
                wr_under      = 1'b1;
            end else begin
                s_wr.timer    = i_write_value - 1'b1;
                s_wr.flags    = pit_pkg::FLAGS_CLEAR;
                s_wr.count    = iv;
                s_wr.interval = iv;
            end
        end
    end

    // divider decrement and count pulse
    always_comb begin
        s_dec       = s_wr;
        s_dec.count = s_wr.count - 1'b1;
        cnt_under   = 1'b0;
        if (s_dec.count == '0) begin
            if (s_wr.timer == '0) begin
                s_dec.timer    = pit_pkg::TIMER_RELOAD;
                s_dec.flags    = pit_pkg::FLAGS_SET;
                s_dec.count    = pit_pkg::DIV_1;
                s_dec.interval = pit_pkg::DIV_1;
                cnt_under      = 1'b1;
            end else begin
                s_dec.count = s_wr.interval;
                s_dec.timer = s_wr.timer - 1'b1;
            end
        end
    end

    assign o_nxt       = s_dec;
    assign o_underflow = wr_under | cnt_under;

endmodule

// ===== rtl/prescaled_interval_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prescaled_interval_timer_core
// Interval timer with a 1/8/64/1024 prescaler; one beat in per machine cycle,
// one beat out per machine cycle with the timer value, flags and underflow marker.
// ----------------------------------------------------------------------------
// path: input register, then the step logic into the result register
// throughput: one beat per cycle unless the result side back-pressures;
//   the timer state updates in the same edge that moves a beat from the
//   input register to the result register
// reset: synchronous active low; timer and flags clear, divider count and
//   interval load 1024, both pipeline stages empty
module prescaled_interval_timer_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave side
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [0] write_valid, [8:1] write_value, [10:9] prescale_select, [15:11] zero
    input  logic [pit_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // master side
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] timer_value, [9:8] status_flags, [10] underflow_event, [15:11] zero
    output logic [pit_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

    // input register
    logic                              r_in_valid;
    logic                              r_in_wv;
    logic [pit_pkg::TIMER_W-1:0]       r_in_val;
    logic [pit_pkg::SEL_W-1:0]         r_in_sel;

    // result register
    logic                              r_out_valid;
    logic [pit_pkg::TIMER_W-1:0]       r_out_timer;
    logic [pit_pkg::FLAG_W-1:0]        r_out_flags;
    logic                              r_out_under;

    // timer state
    pit_pkg::t_state                   r_state;
    pit_pkg::t_state                   n_state;
    logic                              n_under;

    logic                              out_free;
    logic                              advance;
    logic                              in_take;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    // input beat capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_wv  <= s_axis_tdata[0];
            r_in_val <= s_axis_tdata[8:1];
            r_in_sel <= s_axis_tdata[10:9];
        end
    end

    // one machine cycle of the timer
    pit_step u_step (
        .i_cur             (r_state),
        .i_write_valid     (r_in_wv),
        .i_write_value     (r_in_val),
        .i_prescale_select (r_in_sel),
        .o_nxt             (n_state),
        .o_underflow       (n_under)
    );

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pit_pkg::STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_timer <= n_state.timer;
            r_out_flags <= n_state.flags;
            r_out_under <= n_under;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out_under, r_out_flags, r_out_timer};

    // checks
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count != '0)
        else $error("divider count reached zero in state");

    a_count_le_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.count <= r_state.interval)
        else $error("divider count above interval");

    a_interval_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state.interval))
        else $error("divider interval not a prescale value");

    a_under_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_under) |-> (r_out_flags == pit_pkg::FLAGS_SET))
        else $error("underflow without both flags set");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_state))
        else $error("timer state changed without a beat");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for prescaled_interval_timer_core. Machine-cycle beats
// (timer writes and plain ticks) are streamed in under bursty traffic while
// the result side back-pressures on a changing pattern, with long hold-offs
// that fill the block. A behavioral timer model runs alongside and every
// result beat is compared field by field against it.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned RANDOM_BEATS = 1550;

    // model state of the timer
    typedef struct {
        logic [pit_pkg::TIMER_W-1:0] timer;
        logic [pit_pkg::FLAG_W-1:0]  flags;
        logic [pit_pkg::COUNT_W-1:0] count;
        logic [pit_pkg::COUNT_W-1:0] interval;
    } t_timer_model;

    // expected fields of one result beat
    typedef struct packed {
        logic [pit_pkg::TIMER_W-1:0] timer;
        logic [pit_pkg::FLAG_W-1:0]  flags;
        logic                        underflow;
    } t_tick_result;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    logic [pit_pkg::IN_DATA_W-1:0]  s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    logic [pit_pkg::OUT_DATA_W-1:0] m_axis_tdata;

    logic [pit_pkg::IN_DATA_W-1:0] cycle_beats[$];
    t_tick_result                  expected_ticks[$];
    t_timer_model                  model;
    int                            errors;
    logic                          in_taken;
    int                            burst_left;
    int                            gap_left;
    int                            cycle_cnt;
    logic                          rx_hold;
    logic [7:0]                    rx_phase;
    logic [1:0]                    rx_mode;

    prescaled_interval_timer_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // one divider pulse of the model; returns 1 on underflow
    function automatic logic divider_pulse();
        if (model.timer == '0) begin
            model.flags    = pit_pkg::FLAGS_SET;
            model.timer    = pit_pkg::TIMER_RELOAD;
            model.interval = pit_pkg::DIV_1;
            model.count    = pit_pkg::DIV_1;
            return 1'b1;
        end
        model.count = model.interval;
        model.timer = model.timer - 1'b1;
        return 1'b0;
    endfunction

    // advance the model by one machine cycle and give the result beat
    function automatic t_tick_result advance_timer(
        input logic [pit_pkg::IN_DATA_W-1:0] beat
    );
        t_tick_result                res;
        logic                        wr;
        logic [pit_pkg::TIMER_W-1:0] val;
        logic [pit_pkg::SEL_W-1:0]   sel;
        logic [pit_pkg::COUNT_W-1:0] iv;
        logic                        under;
        wr    = beat[0];
        val   = beat[8:1];
        sel   = beat[10:9];
        under = 1'b0;
        // timer write: load, clear flags, set divider, pulse at once
        if (wr) begin
            case (sel)
                pit_pkg::SEL_DIV1:  iv = pit_pkg::DIV_1;
                pit_pkg::SEL_DIV8:  iv = pit_pkg::DIV_8;
                pit_pkg::SEL_DIV64: iv = pit_pkg::DIV_64;
                default:            iv = pit_pkg::DIV_1024;
            endcase
            model.timer    = val;
            model.flags    = pit_pkg::FLAGS_CLEAR;
            model.count    = iv;
            model.interval = iv;
            if (divider_pulse())
                under = 1'b1;
        end
        // divider tick of every cycle
        model.count = model.count - 1'b1;
        if (model.count == '0) begin
            if (divider_pulse())
                under = 1'b1;
        end
        res.timer     = model.timer;
        res.flags     = model.flags;
        res.underflow = under;
        return res;
    endfunction

    function automatic logic [pit_pkg::IN_DATA_W-1:0] pack_cycle(
        input logic                        wr,
        input logic [pit_pkg::TIMER_W-1:0] val,
        input logic [pit_pkg::SEL_W-1:0]   sel
    );
        return {5'b0, sel, val, wr};
    endfunction

    function automatic logic [pit_pkg::SEL_W-1:0] pick_prescale();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return pit_pkg::SEL_DIV1;
        if (r < 80) return pit_pkg::SEL_DIV8;
        if (r < 95) return pit_pkg::SEL_DIV64;
        return pit_pkg::SEL_DIV1024;
    endfunction

    // input driver: bursts of beats with random gaps, changes on falling edge
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || in_taken) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (cycle_beats.size() > 0) begin
                    s_axis_tdata  <= cycle_beats.pop_front();
                    s_axis_tvalid <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result-side ready pattern, changes on falling edge
    always @(negedge i_clk) begin : rx_pattern
        logic rdy;
        case (rx_mode)
            2'd0:    rdy = 1'b1;
            2'd1:    rdy = ($urandom_range(0, 3) != 0);
            2'd2:    rdy = (rx_phase[1:0] == 2'd0);
            default: rdy = 1'($urandom_range(0, 1));
        endcase
        if (rx_hold)
            rdy = 1'b0;
        m_axis_tready <= rdy;
        rx_phase      <= rx_phase + 1'b1;
        if (rx_phase[5:0] == 6'd0)
            rx_mode <= 2'($urandom_range(0, 3));
    end

    // long receiver hold-offs so the block fills and stalls its input
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        rx_hold   <= (cycle_cnt >= 400 && cycle_cnt < 600) ||
                     (cycle_cnt >= 3000 && cycle_cnt < 3300);
    end

    // predict on input beats, check result beats
    always @(posedge i_clk) begin
        t_tick_result exp_r;
        t_tick_result got_r;
        in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && s_axis_tvalid && s_axis_tready)
            expected_ticks.push_back(advance_timer(s_axis_tdata));
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_r.timer     = m_axis_tdata[7:0];
            got_r.flags     = m_axis_tdata[9:8];
            got_r.underflow = m_axis_tdata[10];
            if (expected_ticks.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, got %h",
                         $realtime, m_axis_tdata);
            end else begin
                exp_r = expected_ticks.pop_front();
                if (got_r.timer !== exp_r.timer) begin
                    errors++;
                    $display("%0t: timer_value expected %h got %h",
                             $realtime, exp_r.timer, got_r.timer);
                end
                if (got_r.flags !== exp_r.flags) begin
                    errors++;
                    $display("%0t: status_flags expected %b got %b",
                             $realtime, exp_r.flags, got_r.flags);
                end
                if (got_r.underflow !== exp_r.underflow) begin
                    errors++;
                    $display("%0t: underflow_event expected %b got %b",
                             $realtime, exp_r.underflow, got_r.underflow);
                end
            end
        end
    end

    // timeout
    initial begin
        #3_000_000;
        $display("prescaled_interval_timer_core regression: fail");
        $finish;
    end

    // stimulus, reset and end of run
    initial begin
        int n;
        int run;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        i_rst_n        = 1'b0;
        in_taken       = 1'b0;
        errors         = 0;
        burst_left     = 8;
        gap_left       = 0;
        cycle_cnt      = 0;
        rx_hold        = 1'b0;
        rx_phase       = '0;
        rx_mode        = 2'd0;
        model.timer    = '0;
        model.flags    = pit_pkg::FLAGS_CLEAR;
        model.count    = pit_pkg::DIV_1024;
        model.interval = pit_pkg::DIV_1024;

        // directed: ticks from reset with noise in the ignored fields
        cycle_beats.push_back(pack_cycle(1'b0, 8'hFF, pit_pkg::SEL_DIV1024));
        cycle_beats.push_back(pack_cycle(1'b0, 8'h00, pit_pkg::SEL_DIV1));
        cycle_beats.push_back(pack_cycle(1'b0, 8'hAA, pit_pkg::SEL_DIV8));
        // write of zero underflows at once
        cycle_beats.push_back(pack_cycle(1'b1, 8'h00, pit_pkg::SEL_DIV1));
        cycle_beats.push_back(pack_cycle(1'b0, 8'h55, pit_pkg::SEL_DIV64));
        // writes under the /1024, /8 and /64 prescales, the first one full-scale
        cycle_beats.push_back(pack_cycle(1'b1, 8'hFF, pit_pkg::SEL_DIV1024));
        cycle_beats.push_back(pack_cycle(1'b0, 8'h00, pit_pkg::SEL_DIV1));
        cycle_beats.push_back(pack_cycle(1'b1, 8'h01, pit_pkg::SEL_DIV8));
        for (int k = 0; k < 9; k++)
            cycle_beats.push_back(pack_cycle(1'b0, 8'h00, pit_pkg::SEL_DIV1));
        cycle_beats.push_back(pack_cycle(1'b1, 8'h03, pit_pkg::SEL_DIV64));
        cycle_beats.push_back(pack_cycle(1'b0, 8'hFF, pit_pkg::SEL_DIV1024));
        cycle_beats.push_back(pack_cycle(1'b1, 8'h00, pit_pkg::SEL_DIV1024));
        cycle_beats.push_back(pack_cycle(1'b0, 8'h00, pit_pkg::SEL_DIV1));
        // back-to-back writes
        cycle_beats.push_back(pack_cycle(1'b1, 8'h80, pit_pkg::SEL_DIV8));
        cycle_beats.push_back(pack_cycle(1'b1, 8'h7F, pit_pkg::SEL_DIV1));
        cycle_beats.push_back(pack_cycle(1'b1, 8'h01, pit_pkg::SEL_DIV1));
        cycle_beats.push_back(pack_cycle(1'b0, 8'h00, pit_pkg::SEL_DIV1));
        cycle_beats.push_back(pack_cycle(1'b0, 8'h00, pit_pkg::SEL_DIV1));

        // random: mostly a write with mostly small values, then a run of plain ticks
        n = 0;
        while (n < RANDOM_BEATS) begin
            if ($urandom_range(0, 9) != 0)
                cycle_beats.push_back(pack_cycle(1'b1,
                    ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 6))
                                               : 8'($urandom_range(0, 255)),
                    pick_prescale()));
            else
                cycle_beats.push_back(pack_cycle(1'b0, 8'($urandom_range(0, 255)),
                                                 2'($urandom_range(0, 3))));
            n++;
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(250, 320) : $urandom_range(0, 60);
            for (int k = 0; k < run && n < RANDOM_BEATS; k++) begin
                cycle_beats.push_back(pack_cycle(1'b0, 8'($urandom_range(0, 255)),
                                                 2'($urandom_range(0, 3))));
                n++;
            end
        end

        // hold reset, then release it on a falling edge
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // drain
        while (cycle_beats.size() != 0 || s_axis_tvalid || expected_ticks.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (expected_ticks.size() != 0) begin
            errors++;
            $display("%0t: %0d result beats expected but never seen",
                     $realtime, expected_ticks.size());
        end
        if (errors == 0)
            $display("prescaled_interval_timer_core regression: pass");
        else
            $display("prescaled_interval_timer_core regression: fail");
        $finish;
    end

endmodule
